/* sv/qdfs_pkg.sv */
// Shared types and constants for the quoted delimited field splitter.
// No dependencies; imported by every module of the block.
package qdfs_pkg;

    localparam int ROW_BITS = 16;
    localparam int COL_BITS = 10;
    localparam int SKIP_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] NL_BYTE = 8'd10;
    localparam logic [7:0] BACKSLASH_BYTE = 8'd92;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DELIMITER = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUOTE_CHAR = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP_LINES = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef struct packed {
        logic [7:0]           delimiter;
        logic [7:0]           quote_char;
        logic [SKIP_BITS-1:0] skip_lines;
    } t_cfg;

    // One classified input byte: optional flushed data byte, optional end marker.
    typedef struct packed {
        logic                has_data;
        logic                has_end;
        logic [7:0]          data_byte;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } t_action;

    typedef struct packed {
        logic    full;
        logic    empty;
        t_action head;
    } t_queue_status;

endpackage

/* sv/qdfs_front.sv */
// Front end: accepts stream bytes, tracks quote, delimiter and line state,
// and turns accepted bytes into queued actions where they give a result. Depends on qdfs_pkg.
module qdfs_front import qdfs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic    [7:0] i_byte_in,
    input  logic    i_queue_full,
    output logic    o_push,
    output t_action o_action
);

    logic                 r_quoted, n_quoted;
    logic                 r_prev_delim, n_prev_delim;
    logic                 r_prev_bs, n_prev_bs;
    logic                 r_held_valid, n_held_valid;
    logic [7:0]           r_held_byte, n_held_byte;
    logic [ROW_BITS-1:0]  r_row, n_row;
    logic [COL_BITS-1:0]  r_col, n_col;
    logic [SKIP_BITS-1:0] r_skipped, n_skipped;

    logic    w_accept;
    logic    w_skipping;
    t_action w_act;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_skipping = r_skipped < i_cfg.skip_lines;

    always_comb begin
        n_quoted     = r_quoted;
        n_prev_delim = r_prev_delim;
        n_prev_bs    = r_prev_bs;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_row        = r_row;
        n_col        = r_col;
        n_skipped    = r_skipped;
        w_act.has_data  = 1'b0;
        w_act.has_end   = 1'b0;
        w_act.data_byte = r_held_byte;
        w_act.row       = r_row;
        w_act.col       = r_col;

        if (w_skipping) begin
            if (i_byte_in == NL_BYTE) begin
                n_skipped = r_skipped + 1'b1;
            end
        end else begin
            if (i_byte_in == i_cfg.quote_char) begin
                if (r_prev_bs) begin
                    n_held_byte  = i_byte_in;
                    n_held_valid = 1'b1;
                end else begin
                    n_quoted = !r_quoted;
                end
            end else if ((i_byte_in == i_cfg.delimiter || i_byte_in == NL_BYTE) && !r_quoted) begin
                if (!r_prev_delim) begin
                    w_act.has_data = r_held_valid;
                    w_act.has_end  = 1'b1;
                    n_held_valid   = 1'b0;
                    if (r_col != {COL_BITS{1'b1}}) begin
                        n_col = r_col + 1'b1;
                    end
                end
            end else if (i_byte_in != NL_BYTE) begin
                w_act.has_data = r_held_valid;
                n_held_byte    = i_byte_in;
                n_held_valid   = 1'b1;
            end

            if (i_byte_in == NL_BYTE) begin
                if (r_row != {ROW_BITS{1'b1}}) begin
                    n_row = r_row + 1'b1;
                end
                n_col        = '0;
                n_prev_delim = 1'b1;
                n_prev_bs    = 1'b0;
                n_held_valid = 1'b0;
            end else begin
                n_prev_delim = (i_byte_in == i_cfg.delimiter);
                n_prev_bs    = (i_byte_in == BACKSLASH_BYTE);
            end
        end
    end

    assign o_push   = w_accept && !w_skipping && (w_act.has_data || w_act.has_end);
    assign o_action = w_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted     <= 1'b0;
            r_prev_delim <= 1'b1;
            r_prev_bs    <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_skipped    <= '0;
        end else if (w_accept) begin
            r_quoted     <= n_quoted;
            r_prev_delim <= n_prev_delim;
            r_prev_bs    <= n_prev_bs;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_row        <= n_row;
            r_col        <= n_col;
            r_skipped    <= n_skipped;
        end
    end

endmodule

/* sv/qdfs_queue.sv */
// Short action queue between front end and result sequencer.
// Depends on qdfs_pkg.
module qdfs_queue import qdfs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_action       i_action,
    input  logic          i_pop,
    output t_queue_status o_status
);

    t_action               r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr;
    logic [QPTR_BITS-1:0]  r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_status.full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.head  = r_mem[r_rd_ptr];

endmodule

/* sv/qdfs_back.sv */
// Result sequencer: expands queued actions into data and end-marker results
// through a registered output stage. Depends on qdfs_pkg.
module qdfs_back import qdfs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_queue_status       i_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic [7:0]          o_data_byte,
    output logic [ROW_BITS-1:0] o_row_index,
    output logic [COL_BITS-1:0] o_col_index,
    output logic                o_last_of_input
);

    logic                r_valid;
    logic                r_sub, n_sub;
    logic                r_kind, n_kind;
    logic [7:0]          r_data, n_data;
    logic [ROW_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;
    logic                r_last, n_last;
    logic                w_load;

    assign w_load = (!r_valid || i_ready) && !i_status.empty;

    always_comb begin
        n_sub  = r_sub;
        o_pop  = 1'b0;
        n_kind = KIND_END;
        n_data = '0;
        n_last = 1'b1;
        if (i_status.head.has_data && !r_sub) begin
            n_kind = KIND_DATA;
            n_data = i_status.head.data_byte;
            n_last = !i_status.head.has_end;
            if (w_load) begin
                if (i_status.head.has_end) begin
                    n_sub = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end
        end else if (w_load) begin
            o_pop = 1'b1;
            n_sub = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_sub <= n_sub;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_row  <= i_status.head.row;
            r_col  <= i_status.head.col;
            r_last <= n_last;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data;
    assign o_row_index     = r_row;
    assign o_col_index     = r_col;
    assign o_last_of_input = r_last;

endmodule

/* sv/quoted_delimited_field_splitter_core.sv */
// Top level of the quoted delimited field splitter: configuration registers,
// front end, action queue and result sequencer. Depends on qdfs_pkg and
// qdfs_front, qdfs_queue, qdfs_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_byte_in) takes one text byte a
//   cycle. Output channel (o_out_valid / i_out_ready) gives results with
//   kind, data byte, row, column and a flag on the last result of a byte.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 delimiter, 1 quote byte, 2 header lines to skip). The user writes only
//   while idle; the block does not enforce it. Results pass the queue and the
//   output register. Throughput: one byte per cycle; the result sequencer
//   sends one result a cycle while i_out_ready is high, so a byte that closes
//   a field with a held byte gives two results. The four-entry action queue
//   absorbs that; o_in_ready drops only when the queue is full.
//   Reset clears all line, quote and counter state and loads the default
//   configuration (comma, double quote, no header lines).
//   When the receiver stalls, the output register holds its result and the
//   queue fills; then the input side stalls too. No result is lost.
module quoted_delimited_field_splitter_core import qdfs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_byte_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_kind,
    output logic [7:0]               o_data_byte,
    output logic [ROW_BITS-1:0]      o_row_index,
    output logic [COL_BITS-1:0]      o_col_index,
    output logic                     o_last_of_input
);

    t_cfg          r_cfg;
    logic          w_push;
    logic          w_pop;
    t_action       w_action;
    t_queue_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter  <= DELIM_RESET;
            r_cfg.quote_char <= QUOTE_RESET;
            r_cfg.skip_lines <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIMITER:  r_cfg.delimiter  <= i_cfg_data[7:0];
                CFG_QUOTE_CHAR: r_cfg.quote_char <= i_cfg_data[7:0];
                CFG_SKIP_LINES: r_cfg.skip_lines <= i_cfg_data[SKIP_BITS-1:0];
                default: ;
            endcase
        end
    end

    qdfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_byte_in    (i_byte_in),
        .i_queue_full (w_status.full),
        .o_push       (w_push),
        .o_action     (w_action)
    );

    qdfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_action (w_action),
        .i_pop    (w_pop),
        .o_status (w_status)
    );

    qdfs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_status        (w_status),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_last_of_input (o_last_of_input)
    );

endmodule

/* tb/quoted_delimited_field_splitter_core_test.sv */
// Self-checking bench for quoted_delimited_field_splitter_core: directed byte table, then
// random CSV-like lines under several delimiter/quote/skip settings.
// Depends on qdfs_pkg and the RTL of the block; checked by in-bench predictor or typed rows.
module quoted_delimited_field_splitter_core_test import qdfs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam logic FEED = 1'b0;
    localparam logic SETUP = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [7:0]          data;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } t_split_result;

    typedef struct packed {
        logic                     op;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] val;
        logic                     typed;
        logic [1:0]               n;
        t_split_result            r0;
        t_split_result            r1;
    } t_script_row;

    localparam t_split_result NO_RES = '0;
    localparam t_script_row NO_SCRIPT = '0;
    localparam int SCRIPT_LEN = 35;

    // typed rows: fixed expectations straight after reset with default settings
    t_script_row script [SCRIPT_LEN] = '{
        '{FEED, CFG_DELIMITER, 16'h0061, 1'b1, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0000, 1'b1, 2'd1,
          '{KIND_DATA, 8'h61, 16'd0, 10'd0, 1'b1}, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h002C, 1'b1, 2'd2,
          '{KIND_DATA, 8'h00, 16'd0, 10'd0, 1'b0}, '{KIND_END, 8'h00, 16'd0, 10'd0, 1'b1}},
        '{FEED, CFG_DELIMITER, 16'h002C, 1'b1, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h00FF, 1'b1, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h005C, 1'b1, 2'd1,
          '{KIND_DATA, 8'hFF, 16'd0, 10'd1, 1'b1}, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0022, 1'b1, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h002C, 1'b1, 2'd2,
          '{KIND_DATA, 8'h22, 16'd0, 10'd1, 1'b0}, '{KIND_END, 8'h00, 16'd0, 10'd1, 1'b1}},
        '{FEED, CFG_DELIMITER, 16'h0022, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h002C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0062, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0022, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h000A, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h000A, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0022, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0063, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h000A, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0022, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0064, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h000A, 1'b0, 2'd0, NO_RES, NO_RES},
        '{SETUP, CFG_DELIMITER, 16'hA55C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0065, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h005C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0022, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h000A, 1'b0, 2'd0, NO_RES, NO_RES},
        '{SETUP, CFG_QUOTE_CHAR, 16'h5A5C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0066, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h005C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h005C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h000A, 1'b0, 2'd0, NO_RES, NO_RES},
        '{SETUP, CFG_UNUSED, 16'hFFFF, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h0067, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h005C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h002C, 1'b0, 2'd0, NO_RES, NO_RES},
        '{FEED, CFG_DELIMITER, 16'h000A, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = CFG_DELIMITER;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [7:0]               i_byte_in = 8'h00;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_kind;
    logic [7:0]               o_data_byte;
    logic [ROW_BITS-1:0]      o_row_index;
    logic [COL_BITS-1:0]      o_col_index;
    logic                     o_last_of_input;

    quoted_delimited_field_splitter_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_last_of_input(o_last_of_input)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state and settings
    logic [7:0]           cfg_delim;
    logic [7:0]           cfg_quote;
    logic [SKIP_BITS-1:0] cfg_skip;
    logic                 in_quotes;
    logic                 after_delim;
    logic                 after_backslash;
    logic                 hold_full;
    logic [7:0]           hold_byte;
    logic [ROW_BITS-1:0]  row_no;
    logic [COL_BITS-1:0]  col_no;
    logic [SKIP_BITS-1:0] header_lines_seen;

    t_split_result due_results [$];
    t_split_result byte_results [$];
    t_script_row   posted_row = '0;
    int            faults = 0;
    int            fed = 0;
    bit            steady = 1'b0;
    logic [7:0]    gen_delim = DELIM_RESET;
    logic [7:0]    gen_quote = QUOTE_RESET;

    function automatic void note_result(input logic kind, input logic [7:0] data);
        byte_results.push_back('{kind: kind, data: data, row: row_no, col: col_no, last: 1'b0});
    endfunction

    function automatic void split_byte(input logic [7:0] c);
        byte_results.delete();
        if (header_lines_seen < cfg_skip) begin
            if (c == NL_BYTE)
                header_lines_seen++;
            return;
        end
        if (c == cfg_quote) begin
            if (after_backslash) begin
                hold_byte = c;
                hold_full = 1'b1;
            end else begin
                in_quotes = !in_quotes;
            end
        end else if ((c == cfg_delim || c == NL_BYTE) && !in_quotes) begin
            if (!after_delim) begin
                if (hold_full)
                    note_result(KIND_DATA, hold_byte);
                note_result(KIND_END, 8'h00);
                hold_full = 1'b0;
                if (col_no != '1)
                    col_no++;
            end
        end else if (c != NL_BYTE) begin
            if (hold_full)
                note_result(KIND_DATA, hold_byte);
            hold_byte = c;
            hold_full = 1'b1;
        end
        if (c == NL_BYTE) begin
            if (row_no != '1)
                row_no++;
            col_no = '0;
            after_delim = 1'b1;
            after_backslash = 1'b0;
            hold_full = 1'b0;
        end else begin
            after_delim = (c == cfg_delim);
            after_backslash = (c == BACKSLASH_BYTE);
        end
        if (byte_results.size() > 0)
            byte_results[$].last = 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            faults++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_split_result want;
        if (!i_rst_n) begin
            cfg_delim = DELIM_RESET;
            cfg_quote = QUOTE_RESET;
            cfg_skip = '0;
            in_quotes = 1'b0;
            after_delim = 1'b1;
            after_backslash = 1'b0;
            hold_full = 1'b0;
            hold_byte = 8'h00;
            row_no = '0;
            col_no = '0;
            header_lines_seen = '0;
            due_results.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with nothing outstanding, kind %0h data %0h",
                             $time, o_kind, o_data_byte);
                    faults++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(o_kind));
                    check_field("data_byte", 16'(want.data), 16'(o_data_byte));
                    check_field("row_index", 16'(want.row), 16'(o_row_index));
                    check_field("col_index", 16'(want.col), 16'(o_col_index));
                    check_field("last_of_input", 16'(want.last), 16'(o_last_of_input));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELIMITER: cfg_delim = i_cfg_data[7:0];
                    CFG_QUOTE_CHAR: cfg_quote = i_cfg_data[7:0];
                    CFG_SKIP_LINES: cfg_skip = i_cfg_data[SKIP_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                split_byte(i_byte_in);
                if (posted_row.typed) begin
                    if (posted_row.n > 0)
                        due_results.push_back(posted_row.r0);
                    if (posted_row.n > 1)
                        due_results.push_back(posted_row.r1);
                end else begin
                    foreach (byte_results[k])
                        due_results.push_back(byte_results[k]);
                end
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [7:0] field_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == NL_BYTE || b == gen_delim || b == gen_quote || b == BACKSLASH_BYTE)
            b = 8'h61 + 8'($urandom_range(0, 25));
        return b;
    endfunction

    initial begin : sink_pacing
        int stall;
        forever begin
            @(posedge i_clk);
            stall = steady ? 0 : idle_len();
            if (stall == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input t_script_row pin);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in <= b;
        posted_row <= pin;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        fed++;
    endtask

    // drain: every expected result back, then room for bytes that give none
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_line();
        int nf;
        int f;
        int kind;
        int len;
        int pick;
        if (!steady && $urandom_range(0, 19) == 0)
            steady = 1'b1;
        else if (steady && $urandom_range(0, 4) == 0)
            steady = 1'b0;
        nf = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0)
            push_byte(gen_delim, NO_SCRIPT);
        for (f = 0; f < nf; f++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                len = $urandom_range(1, 4);
                repeat (len) push_byte(field_byte(), NO_SCRIPT);
            end else if (kind < 9) begin
                push_byte(gen_quote, NO_SCRIPT);
                len = $urandom_range(0, 4);
                repeat (len) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3) begin
                        push_byte(gen_delim, NO_SCRIPT);
                    end else if (pick == 3) begin
                        push_byte(BACKSLASH_BYTE, NO_SCRIPT);
                        push_byte(gen_quote, NO_SCRIPT);
                    end else if (pick == 4 && $urandom_range(0, 3) == 0) begin
                        push_byte(NL_BYTE, NO_SCRIPT);
                    end else begin
                        push_byte(field_byte(), NO_SCRIPT);
                    end
                end
                push_byte(gen_quote, NO_SCRIPT);
            end else begin
                push_byte(field_byte(), NO_SCRIPT);
                push_byte(BACKSLASH_BYTE, NO_SCRIPT);
                push_byte(gen_quote, NO_SCRIPT);
            end
            if (f < nf - 1) begin
                push_byte(gen_delim, NO_SCRIPT);
                if ($urandom_range(0, 4) == 0)
                    push_byte(gen_delim, NO_SCRIPT);
            end
        end
        push_byte(NL_BYTE, NO_SCRIPT);
    endtask

    task automatic stream_phase(input logic [7:0] d, input logic [7:0] q, input int skip,
                                input int count);
        int target;
        settle();
        write_reg(CFG_DELIMITER, {8'($urandom), d});
        write_reg(CFG_QUOTE_CHAR, {8'($urandom), q});
        if (skip >= 0)
            write_reg(CFG_SKIP_LINES, 16'(skip));
        gen_delim = d;
        gen_quote = q;
        steady = 1'b0;
        target = fed + count;
        while (fed < target) begin
            if ($urandom_range(0, 9) < 9)
                send_line();
            else
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom), NO_SCRIPT);
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].op == SETUP) begin
                settle();
                write_reg(script[k].idx, script[k].val);
            end else begin
                push_byte(script[k].val[7:0], script[k]);
            end
        end

        stream_phase(DELIM_RESET, QUOTE_RESET, -1, 150);
        stream_phase(8'h3B, 8'h27, 2, 130);
        stream_phase(8'h00, 8'hFF, -1, 110);
        stream_phase(8'hFF, 8'h00, -1, 110);
        stream_phase(8'h7C, 8'h7C, -1, 100);

        settle();
        if (faults == 0 && due_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
sv/qdfs_pkg.sv
sv/qdfs_front.sv
sv/qdfs_queue.sv
sv/qdfs_back.sv
sv/quoted_delimited_field_splitter_core.sv
tb/quoted_delimited_field_splitter_core_test.sv
